// File: sv/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared constants and types for the slot pool buffer manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slp_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_ENQ     = 2'd2,
    MODE_DEQ     = 2'd3
  } mode_t;

  localparam cnt_t FULL_COUNT = CNT_W'(SLOTS);

  // Link value an untouched entry holds after reset.
  function automatic slot_t link_default(input slot_t idx);
    if (idx == SLOT_W'(SLOTS - 1)) begin
      return '0;
    end
    return idx + SLOT_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: sv/slot_pool_with_fifo.sv
// ----------------------------------------------------------------------------
// slot_pool_with_fifo
// Buffer manager over a pool of slots: a LIFO free list and a FIFO of
// allocated slots, both chained through one shared link RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | start / busy         | mode, slot_in
//  result   | done (1-cycle pulse) | slot_out, status, free_left, queued
//
//  The link RAM read issued at accept returns in the next cycle, in
//  ST_EXEC, when the lists are updated; done pulses in the following
//  cycle, during which the next transaction may be accepted.
//  Reset restores the initial chain through per-entry valid bits at once,
//  with no clearing pass. The receiver cannot stall; results are pulsed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slot_pool_with_fifo import slp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        mode,
  input  wire logic [SLOT_W-1:0] slot_in,
  output logic                   done,
  output logic      [SLOT_W-1:0] slot_out,
  output logic                   status,
  output logic      [CNT_W-1:0]  free_left,
  output logic      [CNT_W-1:0]  queued
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  slot_t free_head;
  cnt_t  free_count;
  slot_t fifo_head;
  slot_t fifo_tail;
  cnt_t  fifo_count;

  mode_t mode_q;
  slot_t slot_q;
  slot_t rd_addr;
  slot_t rd_addr_q;
  logic  rd_valid_q;
  slot_t rdata;
  slot_t link_val;

  logic [SLOTS-1:0] link_valid;

  logic  accept;
  logic  we;
  slot_t waddr;
  slot_t wdata;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Dequeue on an empty FIFO reads from the free head instead; data unused.
  assign rd_addr = (mode_t'(mode) == MODE_DEQ && fifo_count != '0) ? fifo_head : free_head;

  // Untouched entries still hold their reset chain value.
  assign link_val = rd_valid_q ? rdata : link_default(rd_addr_q);

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = free_head;
    if (state == ST_EXEC) begin
      case (mode_q)
        MODE_RELEASE: begin
          we    = (free_count != FULL_COUNT);
          waddr = slot_q;
          wdata = free_head;
        end
        MODE_ENQ: begin
          we    = (fifo_count != '0) && (fifo_count != FULL_COUNT);
          waddr = fifo_tail;
          wdata = slot_q;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  slp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      free_head  <= '0;
      free_count <= FULL_COUNT;
      fifo_count <= '0;
      link_valid <= '0;
    end else begin
      done <= 1'b0;
      if (we) begin
        link_valid[waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q     <= mode_t'(mode);
            slot_q     <= slot_in;
            rd_addr_q  <= rd_addr;
            rd_valid_q <= link_valid[rd_addr];
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state    <= ST_IDLE;
          done     <= 1'b1;
          slot_out <= '0;
          status   <= 1'b0;
          case (mode_q)
            MODE_ALLOC: begin
              if (free_count == '0) begin
                status    <= 1'b1;
                free_left <= free_count;
              end else begin
                slot_out   <= free_head;
                free_head  <= link_val;
                free_count <= free_count - CNT_W'(1);
                free_left  <= free_count - CNT_W'(1);
              end
              queued <= fifo_count;
            end
            MODE_RELEASE: begin
              if (free_count != FULL_COUNT) begin
                free_head  <= slot_q;
                free_count <= free_count + CNT_W'(1);
                free_left  <= free_count + CNT_W'(1);
              end else begin
                free_left <= free_count;
              end
              queued <= fifo_count;
            end
            MODE_ENQ: begin
              if (fifo_count != FULL_COUNT) begin
                if (fifo_count == '0) begin
                  fifo_head <= slot_q;
                end
                fifo_tail  <= slot_q;
                fifo_count <= fifo_count + CNT_W'(1);
                queued     <= fifo_count + CNT_W'(1);
              end else begin
                queued <= fifo_count;
              end
              free_left <= free_count;
            end
            default: begin
              if (fifo_count == '0) begin
                status <= 1'b1;
                queued <= fifo_count;
              end else begin
                slot_out   <= fifo_head;
                fifo_head  <= link_val;
                fifo_count <= fifo_count - CNT_W'(1);
                queued     <= fifo_count - CNT_W'(1);
              end
              free_left <= free_count;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/slp_ram.sv
// ----------------------------------------------------------------------------
// slp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: tb/slp_checker.sv
// ----------------------------------------------------------------------------
// slp_checker
// Watches the request and result channels of the slot pool, predicts each
// result from its own copy of the free list, FIFO and link store, and
// compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slp_checker import slp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [1:0]        mode,
  input  wire logic [SLOT_W-1:0] slot_in,
  input  wire logic              done,
  input  wire logic [SLOT_W-1:0] slot_out,
  input  wire logic              status,
  input  wire logic [CNT_W-1:0]  free_left,
  input  wire logic [CNT_W-1:0]  queued,
  output int                     errors,
  output int                     outstanding
);

  typedef struct packed {
    slot_t slot;
    logic  refused;
    cnt_t  free_n;
    cnt_t  queue_n;
  } outcome_t;

  slot_t    links [SLOTS];
  slot_t    free_top;
  cnt_t     free_cnt;
  slot_t    q_head;
  slot_t    q_tail;
  cnt_t     q_cnt;
  outcome_t results_due[$];

  // Applies one transaction to the shadow lists and returns what the block
  // should report for it.
  function automatic outcome_t serve_request(mode_t op, slot_t s);
    outcome_t r;
    r = '0;
    case (op)
      MODE_ALLOC: begin
        if (free_cnt == '0) begin
          r.refused = 1'b1;
        end else begin
          r.slot   = free_top;
          free_top = links[free_top];
          free_cnt = free_cnt - CNT_W'(1);
        end
      end
      MODE_RELEASE: begin
        if (free_cnt < FULL_COUNT) begin
          links[s] = free_top;
          free_top = s;
          free_cnt = free_cnt + CNT_W'(1);
        end
      end
      MODE_ENQ: begin
        if (q_cnt < FULL_COUNT) begin
          if (q_cnt == '0) begin
            q_head = s;
          end else begin
            links[q_tail] = s;
          end
          q_tail = s;
          q_cnt  = q_cnt + CNT_W'(1);
        end
      end
      default: begin
        if (q_cnt == '0) begin
          r.refused = 1'b1;
        end else begin
          r.slot = q_head;
          q_head = links[q_head];
          q_cnt  = q_cnt - CNT_W'(1);
        end
      end
    endcase
    r.free_n  = free_cnt;
    r.queue_n = q_cnt;
    return r;
  endfunction

  function automatic int field_bad(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        links[i] = slot_t'(i + 1);
      end
      free_top = '0;
      free_cnt = FULL_COUNT;
      q_head   = '0;
      q_tail   = '0;
      q_cnt    = '0;
      results_due.delete();
    end else begin
      // result first: a done in the accept cycle belongs to the previous one
      if (done) begin
        if (results_due.size() == 0) begin
          $error("result with no transaction outstanding: slot_out %0d status %0d",
                 slot_out, status);
          bad++;
        end else begin
          want = results_due.pop_front();
          bad += field_bad("slot_out", int'(want.slot), int'(slot_out));
          bad += field_bad("status", int'(want.refused), int'(status));
          bad += field_bad("free_left", int'(want.free_n), int'(free_left));
          bad += field_bad("queued", int'(want.queue_n), int'(queued));
        end
      end
      if (start && !busy) begin
        results_due.push_back(serve_request(mode_t'(mode), slot_in));
      end
    end
    errors      <= errors + bad;
    outstanding <= results_due.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the slot pool buffer manager: a directed opener over the
// empty, full and out-of-pool cases, then random transactions in segments
// biased towards one operation or uniform, some with random request gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import slp_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int SEGMENT      = 120;

  logic  clk     = 1'b0;
  logic  rst     = 1'b1;
  logic  start   = 1'b0;
  mode_t mode    = MODE_ALLOC;
  slot_t slot_in = '0;

  logic              busy;
  logic              done;
  logic [SLOT_W-1:0] slot_out;
  logic              status;
  logic [CNT_W-1:0]  free_left;
  logic [CNT_W-1:0]  queued;
  int                errors;
  int                outstanding;

  // slots handed out by allocate or dequeue, reused as well-formed
  // release and enqueue arguments
  mode_t ops_in_flight[$];
  slot_t held[$];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  slot_pool_with_fifo u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .slot_in  (slot_in),
    .done     (done),
    .slot_out (slot_out),
    .status   (status),
    .free_left(free_left),
    .queued   (queued)
  );

  slp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .slot_in    (slot_in),
    .done       (done),
    .slot_out   (slot_out),
    .status     (status),
    .free_left  (free_left),
    .queued     (queued),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    mode_t op;
    if (!rst) begin
      if (done && ops_in_flight.size() != 0) begin
        op = ops_in_flight.pop_front();
        if (!status && (op == MODE_ALLOC || op == MODE_DEQ)) begin
          held.push_back(slot_out);
        end
      end
      if (start && !busy) begin
        ops_in_flight.push_back(mode);
      end
    end
  end

  // Mostly a slot we hold; now and then any index, held or not.
  function automatic slot_t pick_slot();
    int    idx;
    slot_t s;
    if (held.size() != 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, held.size() - 1);
      s   = held[idx];
      held.delete(idx);
    end else begin
      s = slot_t'($urandom_range(0, SLOTS - 1));
    end
    return s;
  endfunction

  // Returns at the edge where the transaction is taken; start is left high
  // so a back-to-back transaction needs only one assignment.
  task automatic send_item(mode_t op, slot_t s, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    mode    <= op;
    slot_in <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_directed(mode_t op, slot_t s);
    send_item(op, s, $urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
  endtask

  initial begin
    mode_t       op;
    mode_t       bias;
    bit          uniform;
    bit          idling;
    int unsigned roll;
    slot_t       s;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_directed(MODE_RELEASE, 6'd63);  // free list full: ignored
    send_directed(MODE_DEQ, 6'd0);       // FIFO empty: refused
    send_directed(MODE_ALLOC, 6'd63);
    send_directed(MODE_ALLOC, 6'd0);
    send_directed(MODE_ENQ, 6'd0);       // first entry sets the head
    send_directed(MODE_ENQ, 6'd63);
    send_directed(MODE_ENQ, 6'd42);
    send_directed(MODE_ENQ, 6'd21);
    repeat (4) send_directed(MODE_DEQ, 6'd63);
    send_directed(MODE_DEQ, 6'd21);
    send_directed(MODE_RELEASE, 6'd1);
    send_directed(MODE_RELEASE, 6'd0);
    send_directed(MODE_RELEASE, 6'd63);  // full again, ignored
    send_directed(MODE_ENQ, 6'd5);       // slot never allocated
    send_directed(MODE_ALLOC, 6'd21);
    send_directed(MODE_ALLOC, 6'd42);
    send_directed(MODE_DEQ, 6'd0);
    send_directed(MODE_RELEASE, 6'd5);
    held.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0) begin
        bias    = mode_t'($urandom_range(0, 3));
        uniform = ($urandom_range(0, 4) == 0);
        idling  = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (uniform) begin
        op = mode_t'(roll % 4);
      end else if (roll < 70) begin
        op = bias;
      end else begin
        op = mode_t'(bias + 2'(1 + roll % 3));
      end
      if (op == MODE_RELEASE || op == MODE_ENQ) begin
        s = pick_slot();
      end else begin
        s = slot_t'($urandom_range(0, SLOTS - 1));
      end
      send_item(op, s, idling ? $urandom_range(0, 8) : 0);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    #1;
    if (errors == 0 && outstanding == 0) begin
      $display("slot_pool_with_fifo regression: pass");
    end else begin
      $display("slot_pool_with_fifo regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("slot_pool_with_fifo regression: fail");
    $finish;
  end

endmodule

// File: files.f
sv/slp_pkg.sv
sv/slp_ram.sv
sv/slot_pool_with_fifo.sv
tb/slp_checker.sv
tb/tb_top.sv
